// ===== sv/ray_disk_intersection_defines.svh =====
// Assertion macros for the ray/disk block
`ifndef RAY_DISK_INTERSECTION_DEFINES_SVH
`define RAY_DISK_INTERSECTION_DEFINES_SVH
`ifndef ASSERT_OFF
`define RDI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: label");
`define RDI_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define RDI_ASSERT(label, clk, rst_n, prop)
`define RDI_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/rdi_pkg.sv =====
package rdi_pkg;
  localparam int unsigned NumRegs = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NormW = 18;

  typedef enum logic [CfgIdxW-1:0] {
    RegCenterX = 3'd0,
    RegCenterY = 3'd1,
    RegCenterZ = 3'd2,
    RegNormalX = 3'd3,
    RegNormalY = 3'd4,
    RegNormalZ = 3'd5,
    RegRadius  = 3'd6
  } reg_idx_e;

  localparam logic signed [NormW-1:0] NormMax = 18'sd131071;
  localparam logic signed [NormW-1:0] NormMin = -18'sd131072;
endpackage

// ===== sv/rdi_divider.sv =====
// Pipelined restoring divider: quotient bits of num/den, one bit per stage.
// num < 2^53, den < 2^53 (both positive). Gives a 31-bit quotient with the
// integer part saturating; 32 stages: capture, then 31 quotient steps.
module rdi_divider #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned OpW = 54,
  parameter int unsigned TagW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [OpW-1:0]      num_i,
  input  logic [OpW-1:0]      den_i,
  input  logic [TagW-1:0]     tag_i,
  output logic                valid_o,
  output logic [30:0]         quot_o,
  output logic [TagW-1:0]     tag_o
);
  import rdi_pkg::*;
  // Integer quotient must stay below 2^(31-FracBits); check by compare,
  // then 31 bits of long division with the shifted numerator.
  localparam int unsigned IntW = 31 - FracBits;
  localparam int unsigned Steps = 31;
  localparam int unsigned RemW = OpW + 1;

  logic [Steps:0]                valid_q;
  logic [RemW-1:0]               rem_q  [Steps+1];
  logic [OpW-1:0]                den_q  [Steps+1];
  logic [30:0]                   quot_q [Steps+1];
  logic [Steps:0]                sat_q;
  logic [TagW-1:0]               tag_q  [Steps+1];
  // numerator bits still to bring down (numerator scaled by 2^FracBits)
  logic [OpW+FracBits-1:0]       nsh_q  [Steps+1];

  // stage 0: capture and saturation compare (num >= den << IntW)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      sat_q[0]  <= ({{IntW{1'b0}}, num_i} >= ({den_i, {IntW{1'b0}}}));
      tag_q[0]  <= tag_i;
      nsh_q[0]  <= {num_i, {FracBits{1'b0}}};
    end
  end

  // Quotient bits 30..0 of (num<<FracBits)/den; bits above 30 are zero when
  // not saturated. Top OpW+FracBits-30 bits seed the remainder at step 0.
  localparam int unsigned NshW = OpW + FracBits;
  localparam int unsigned SeedW = NshW - Steps + 1;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemW-1:0] cur;
    logic [RemW-1:0] trial;
    logic            ge;
    if (s == 0) begin : g_seed
      assign cur = RemW'(nsh_q[0][NshW-1 -: SeedW]);
    end else begin : g_shift
      assign cur = {rem_q[s][RemW-2:0], nsh_q[s][NshW-1-SeedW-(s-1)]};
    end
    assign ge    = cur >= {1'b0, den_q[s]};
    assign trial = ge ? (cur - {1'b0, den_q[s]}) : cur;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= trial;
        den_q[s+1]  <= den_q[s];
        quot_q[s+1] <= {quot_q[s][29:0], ge};
        sat_q[s+1]  <= sat_q[s];
        tag_q[s+1]  <= tag_q[s];
        nsh_q[s+1]  <= nsh_q[s];
      end
    end
  end

  assign valid_o = valid_q[Steps];
  assign quot_o  = sat_q[Steps] ? 31'h7FFF_FFFF : quot_q[Steps];
  assign tag_o   = tag_q[Steps];
endmodule

// ===== sv/ray_disk_intersection.sv =====
// Ray/disk intersection, fully pipelined.
// Structure: 3 front stages, 32-stage quotient divider, 5 back stages.
// Throughput: one ray per cycle; a stall freezes the whole pipeline.
// Reset (rst_ni low, async): pipeline empties, registers return to centre 0,
// normal (0,0,1), radius 0.
`include "ray_disk_intersection_defines.svh"
module ray_disk_intersection #(
  parameter int unsigned FAR_VALUE = 2147483647,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rdi_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rdi_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             dir_x_i,
  input  logic signed [31:0]             dir_y_i,
  input  logic signed [31:0]             dir_z_i,
  input  logic signed [31:0]             origin_x_i,
  input  logic signed [31:0]             origin_y_i,
  input  logic signed [31:0]             origin_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic signed [31:0]             point_x_o,
  output logic signed [31:0]             point_y_o,
  output logic signed [31:0]             point_z_o,
  output logic signed [17:0]             facing_x_o,
  output logic signed [17:0]             facing_y_o,
  output logic signed [17:0]             facing_z_o
);
  import rdi_pkg::*;

  // ---------------- configuration ----------------
  logic signed [31:0] cen_q [3];
  logic signed [NormW-1:0] nrm_q [3];
  logic [30:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q[0] <= '0; cen_q[1] <= '0; cen_q[2] <= '0;
      nrm_q[0] <= '0; nrm_q[1] <= '0; nrm_q[2] <= 18'sd65536;
      rad_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCenterX: cen_q[0] <= cfg_data_i;
        RegCenterY: cen_q[1] <= cfg_data_i;
        RegCenterZ: cen_q[2] <= cfg_data_i;
        RegNormalX: nrm_q[0] <= cfg_data_i[NormW-1:0];
        RegNormalY: nrm_q[1] <= cfg_data_i[NormW-1:0];
        RegNormalZ: nrm_q[2] <= cfg_data_i[NormW-1:0];
        RegRadius:  rad_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Single output register; whole pipeline advances when it can move.
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- front: dot products ----------------
  // f1: products n*d (18x32) and n*(c-o) (18x33)
  logic               v1_q;
  logic signed [49:0] pd_q [3];
  logic signed [50:0] pn_q [3];
  logic signed [31:0] d1_q [3], o1_q [3];

  logic signed [31:0] din [3], oin [3];
  assign din = '{dir_x_i, dir_y_i, dir_z_i};
  assign oin = '{origin_x_i, origin_y_i, origin_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end
  for (genvar i = 0; i < 3; i++) begin : g_f1
    logic signed [32:0] co;
    assign co = 33'(cen_q[i]) - 33'(oin[i]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pd_q[i] <= 50'(nrm_q[i]) * 50'(din[i]);
        pn_q[i] <= 51'(nrm_q[i]) * 51'(co);
        d1_q[i] <= din[i];
        o1_q[i] <= oin[i];
      end
    end
  end

  // f2: sums
  logic               v2_q;
  logic signed [51:0] dn_q;
  logic signed [52:0] num_q;
  logic signed [31:0] d2_q [3], o2_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dn_q  <= 52'(pd_q[0]) + 52'(pd_q[1]) + 52'(pd_q[2]);
      num_q <= 53'(pn_q[0]) + 53'(pn_q[1]) + 53'(pn_q[2]);
      d2_q  <= d1_q;
      o2_q  <= o1_q;
    end
  end

  // f3: sign fold, positivity check
  localparam int unsigned OpW = 54;
  logic               v3_q, ok3_q;
  logic [OpW-1:0]     nu3_q, du3_q;
  logic signed [31:0] d3_q [3], o3_q [3];
  logic signed [53:0] dnf, nmf;
  assign dnf = dn_q[51] ? -54'(dn_q) : 54'(dn_q);
  assign nmf = dn_q[51] ? -54'(num_q) : 54'(num_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok3_q <= (dn_q != '0) && (nmf > 0);
      nu3_q <= (nmf > 0) ? OpW'(nmf) : '0;
      du3_q <= (dn_q != '0) ? OpW'(dnf) : OpW'(1);
      d3_q  <= d2_q;
      o3_q  <= o2_q;
    end
  end

  // ---------------- divider ----------------
  localparam int unsigned TagW = 1 + 6 * 32;
  logic [TagW-1:0] tag_in, tag_out;
  logic            vdv;
  logic [30:0]     tq;
  assign tag_in = {ok3_q, d3_q[0], d3_q[1], d3_q[2], o3_q[0], o3_q[1], o3_q[2]};
  rdi_divider #(.FracBits(FRAC_BITS), .OpW(OpW), .TagW(TagW)) u_div (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v3_q),
    .num_i(nu3_q), .den_i(du3_q), .tag_i(tag_in),
    .valid_o(vdv), .quot_o(tq), .tag_o(tag_out)
  );

  logic               ok4;
  logic signed [31:0] d4 [3], o4 [3];
  assign {ok4, d4[0], d4[1], d4[2], o4[0], o4[1], o4[2]} = tag_out;

  // b1: t*d (32x32)
  logic               v5_q, ok5_q;
  logic signed [63:0] td_q [3];
  logic signed [31:0] o5_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= vdv;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok5_q <= ok4 && (tq != '0);
      o5_q  <= o4;
      for (int i = 0; i < 3; i++) td_q[i] <= 64'($signed({1'b0, tq})) * 64'(d4[i]);
    end
  end

  // b2: floor shift, add origin, saturate; distance from centre
  logic               v6_q, ok6_q;
  logic signed [31:0] p6_q [3], o6_q [3];
  logic signed [32:0] u6_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (adv) v6_q <= v5_q;
  end
  for (genvar i = 0; i < 3; i++) begin : g_b2
    logic signed [64:0] s;
    logic signed [31:0] ps;
    // arithmetic shift equals floor division by 2^FRAC_BITS
    assign s  = 65'(o5_q[i]) + 65'(td_q[i] >>> FRAC_BITS);
    assign ps = (s > 65'sd2147483647) ? 32'sh7FFF_FFFF :
                (s < -65'sd2147483648) ? 32'sh8000_0000 : 32'(s);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        p6_q[i] <= ps;
        u6_q[i] <= 33'(ps) - 33'(cen_q[i]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok6_q <= ok5_q;
      o6_q  <= o5_q;
    end
  end

  // b3: squares and facing products
  logic               v7_q, ok7_q, near7_q;
  logic [61:0]        sq7_q [3];
  logic signed [51:0] fp7_q [3];
  logic signed [31:0] p7_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (adv) v7_q <= v6_q;
  end
  logic [2:0] far6;
  for (genvar i = 0; i < 3; i++) begin : g_b3
    logic [32:0] um;
    assign um      = u6_q[i][32] ? 33'(-u6_q[i]) : 33'(u6_q[i]);
    assign far6[i] = um[32] | um[31];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq7_q[i] <= 62'(um[30:0]) * 62'(um[30:0]);
        fp7_q[i] <= 52'(33'(p6_q[i]) - 33'(o6_q[i])) * 52'(nrm_q[i]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok7_q   <= ok6_q;
      near7_q <= (far6 == 3'b000);
      p7_q    <= p6_q;
    end
  end

  // b4: square sums and squared radius, facing sign
  logic               v8_q, hit8_q, fneg8_q;
  logic [61:0]        rr8_q;
  logic [63:0]        sum8_q;
  logic signed [31:0] p8_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (adv) v8_q <= v7_q;
  end
  logic signed [53:0] fsum;
  assign fsum = 54'(fp7_q[0]) + 54'(fp7_q[1]) + 54'(fp7_q[2]);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit8_q  <= ok7_q && near7_q;
      sum8_q  <= 64'(sq7_q[0]) + 64'(sq7_q[1]) + 64'(sq7_q[2]);
      rr8_q   <= 62'(rad_q) * 62'(rad_q);
      fneg8_q <= !fsum[53];
      p8_q    <= p7_q;
    end
  end

  // b5: radius compare, output register
  logic ht;
  assign ht = hit8_q && (sum8_q < 64'(rr8_q));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= v8_q;
  end
  logic signed [NormW-1:0] fo [3];
  for (genvar i = 0; i < 3; i++) begin : g_face
    assign fo[i] = !fneg8_q ? nrm_q[i] :
                   (nrm_q[i] == NormMin) ? NormMax : -nrm_q[i];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_o      <= ht;
      point_x_o  <= ht ? p8_q[0] : 32'(FAR_VALUE);
      point_y_o  <= ht ? p8_q[1] : 32'(FAR_VALUE);
      point_z_o  <= ht ? p8_q[2] : 32'(FAR_VALUE);
      facing_x_o <= ht ? fo[0] : '0;
      facing_y_o <= ht ? fo[1] : '0;
      facing_z_o <= ht ? fo[2] : '0;
    end
  end

  `RDI_ASSERT(a_stall_only_when_full, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i)
  `RDI_ASSERT(a_out_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(point_x_o))
  `RDI_ASSERT(a_miss_far, clk_i, rst_ni, out_valid_o && !hit_o |-> facing_x_o == '0 && facing_z_o == '0)
  `RDI_ASSERT_NR(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)
endmodule

// ===== verif/tb_ray_disk_intersection.sv =====
module tb_ray_disk_intersection;
  import rdi_pkg::*;

  localparam logic signed [31:0] FarPoint = 32'sh7fffffff;
  localparam logic signed [31:0] OneQ = 32'sd65536;
  localparam int HoldCycles = 400;
  localparam int WatchdogLimit = 5000;

  typedef struct {
    logic signed [31:0] dir [3];
    logic signed [31:0] org [3];
  } ray_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] pt [3];
    logic signed [17:0] fc [3];
  } hit_info_t;

  typedef struct {
    ray_t      ray;
    bit        typed;
    hit_info_t res;
  } ray_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic signed [31:0] point_x_o, point_y_o, point_z_o;
  logic signed [17:0] facing_x_o, facing_y_o, facing_z_o;

  ray_disk_intersection dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // disk as last written
  logic signed [31:0] disk_ctr [3];
  logic signed [17:0] disk_nrm [3];
  logic [30:0] disk_rad;

  hit_info_t pending_hits [$];
  ray_row_t rows [$];
  int errors = 0;
  int n_hits = 0, n_miss = 0, n_rays = 0, n_cfg = 0;
  int idle_pct = 0, stall_pct = 0;
  bit hold_go = 1'b0, hold_used = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic hit_info_t miss_info();
    hit_info_t m;
    m.hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      m.pt[i] = FarPoint;
      m.fc[i] = '0;
    end
    return m;
  endfunction

  function automatic hit_info_t trace_ray(ray_t r);
    longint d [3], o [3], c [3], n [3], p [3];
    longint dn, num, f, u, fn;
    longint unsigned nu, du, q, rm, t, sum, um, rad;
    bit near;
    hit_info_t res;
    dn = 0;
    num = 0;
    f = 0;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = r.dir[i];
      o[i] = r.org[i];
      c[i] = disk_ctr[i];
      n[i] = disk_nrm[i];
      dn += n[i] * d[i];
      num += n[i] * (c[i] - o[i]);
    end
    if (dn == 0) return miss_info();
    if (dn < 0) begin
      dn = -dn;
      num = -num;
    end
    if (num <= 0) return miss_info();
    nu = num;
    du = dn;
    q = nu / du;
    rm = nu % du;
    if (q >= 64'd32768) begin
      t = 64'h7fffffff;
    end else begin
      t = q;
      for (int k = 0; k < 16; k++) begin
        rm = rm << 1;
        t = t << 1;
        if (rm >= du) begin
          rm -= du;
          t |= 64'd1;
        end
      end
    end
    if (t == 0) return miss_info();
    near = 1'b1;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = o[i] + ((longint'(t) * d[i]) >>> 16);
      if (p[i] > 64'sd2147483647) p[i] = 64'sd2147483647;
      if (p[i] < -64'sd2147483648) p[i] = -64'sd2147483648;
      u = p[i] - c[i];
      um = (u < 0) ? -u : u;
      if (um >= 64'h80000000) near = 1'b0;
      else sum += um * um;
    end
    rad = disk_rad;
    if (!near || sum >= rad * rad) return miss_info();
    for (int i = 0; i < 3; i++) f += (p[i] - o[i]) * n[i];
    res.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      fn = n[i];
      if (f >= 0) begin
        fn = -fn;
        if (fn > 131071) fn = 131071;
      end
      res.pt[i] = p[i][31:0];
      res.fc[i] = fn[17:0];
    end
    return res;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_cfg++;
    case (idx)
      RegCenterX, RegCenterY, RegCenterZ: disk_ctr[idx] = val;
      RegNormalX, RegNormalY, RegNormalZ: disk_nrm[idx - RegNormalX] = val[17:0];
      RegRadius: disk_rad = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_disk(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                          logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                          logic [31:0] rad);
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegCenterZ, cz);
    write_reg(RegNormalX, nx);
    write_reg(RegNormalY, ny);
    write_reg(RegNormalZ, nz);
    write_reg(RegRadius, rad);
  endtask

  // every result back before the disk may change
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_ray(ray_t r, bit typed, hit_info_t typed_res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    dir_x_i <= r.dir[0];
    dir_y_i <= r.dir[1];
    dir_z_i <= r.dir[2];
    origin_x_i <= r.org[0];
    origin_y_i <= r.org[1];
    origin_z_i <= r.org[2];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_hits.push_back(typed ? typed_res : trace_ray(r));
    n_rays++;
  endtask

  function automatic ray_t mk_ray(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                  logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
    ray_t r;
    r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
    r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
    return r;
  endfunction

  function automatic void add_row(ray_t r, bit typed, hit_info_t res);
    ray_row_t row;
    row.ray = r;
    row.typed = typed;
    row.res = res;
    rows.push_back(row);
  endfunction

  // mostly rays aimed near the centre from a nearby origin, some pure noise
  function automatic ray_t random_ray();
    ray_t r;
    logic signed [31:0] tgt;
    int spread;
    spread = $urandom_range(3) == 0 ? 30 : 22;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(9) == 0) begin
        r.dir[i] = $urandom;
        r.org[i] = $urandom;
      end else begin
        r.org[i] = disk_ctr[i] + ($signed($urandom) >>> (32 - spread));
        tgt = disk_ctr[i] + ($signed($urandom) >>> 14);
        r.dir[i] = (tgt - r.org[i]) >>> $urandom_range(4);
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] random_normal();
    case ($urandom_range(5))
      0: return 32'(OneQ);
      1: return -32'(OneQ);
      2: return 32'd0;
      3: return 32'h20000;
      default: return $signed($urandom) >>> 14;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    hit_info_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_hits.pop_front();
        if (hit_o) n_hits++; else n_miss++;
        if (hit_o !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, hit_o); errors++;
        end
        if (point_x_o !== e.pt[0]) begin
          $error("point_x: expected %0d, got %0d", e.pt[0], point_x_o); errors++;
        end
        if (point_y_o !== e.pt[1]) begin
          $error("point_y: expected %0d, got %0d", e.pt[1], point_y_o); errors++;
        end
        if (point_z_o !== e.pt[2]) begin
          $error("point_z: expected %0d, got %0d", e.pt[2], point_z_o); errors++;
        end
        if (facing_x_o !== e.fc[0]) begin
          $error("facing_x: expected %0d, got %0d", e.fc[0], facing_x_o); errors++;
        end
        if (facing_y_o !== e.fc[1]) begin
          $error("facing_y: expected %0d, got %0d", e.fc[1], facing_y_o); errors++;
        end
        if (facing_z_o !== e.fc[2]) begin
          $error("facing_z: expected %0d, got %0d", e.fc[2], facing_z_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no beat for %0d cycles", WatchdogLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    hit_info_t m, h;
    for (int i = 0; i < 3; i++) begin
      disk_ctr[i] = '0;
      disk_nrm[i] = '0;
    end
    disk_nrm[2] = 18'sd65536;
    disk_rad = '0;
    m = miss_info();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset disk has zero radius: every ray misses
    add_row(mk_ray(0, 0, 0, 0, 0, OneQ), 1'b1, m);
    add_row(mk_ray(OneQ, 0, 0, 0, 0, OneQ), 1'b1, m);
    add_row(mk_ray(0, 0, -OneQ, 0, 0, 5 * OneQ), 1'b1, m);
    add_row(mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h80000000, 32'h80000000, 32'h80000000), 1'b1, m);
    add_row(mk_ray(32'h80000000, 32'h80000000, 32'h80000000,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b1, m);
    add_row(mk_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0), 1'b1, m);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);
    rows.delete();
    drain();

    write_reg(RegRadius, 10 * OneQ);
    h.hit = 1'b1;
    h.pt[0] = 0; h.pt[1] = 0; h.pt[2] = 0;
    h.fc[0] = 0; h.fc[1] = 0; h.fc[2] = 18'sd65536;
    // straight down onto the centre from above
    add_row(mk_ray(0, 0, -OneQ, 0, 0, 5 * OneQ), 1'b1, h);
    h.fc[2] = -18'sd65536;
    add_row(mk_ray(0, 0, OneQ, 0, 0, -5 * OneQ), 1'b1, h);
    // pointing away, on the plane, parallel
    add_row(mk_ray(0, 0, OneQ, 0, 0, 5 * OneQ), 1'b1, m);
    add_row(mk_ray(0, 0, OneQ, 0, 0, 0), 1'b1, m);
    add_row(mk_ray(OneQ, 0, 0, 0, 0, OneQ), 1'b1, m);
    add_row(mk_ray(0, 0, -OneQ, 10 * OneQ, 0, OneQ), 1'b0, m);
    add_row(mk_ray(0, 0, -OneQ, 10 * OneQ - 1, 0, OneQ), 1'b0, m);
    add_row(mk_ray(0, 0, -1, 0, 0, 32'h7fffffff), 1'b0, m);
    add_row(mk_ray(3 * OneQ, 0, -OneQ, 0, 0, 2 * OneQ), 1'b0, m);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);
    rows.delete();
    drain();

    // extreme normal and widest radius
    set_disk(OneQ, -OneQ, 32'h7fff0000, 32'h20000, 32'h20000, 32'h20000, 32'h7fffffff);
    add_row(mk_ray(OneQ, OneQ, OneQ, 0, 0, 0), 1'b0, m);
    add_row(mk_ray(-OneQ, -OneQ, -OneQ, 0, 0, 0), 1'b0, m);
    add_row(mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0), 1'b0, m);
    add_row(mk_ray(1, 1, 1, 32'h80000000, 32'h80000000, 32'h80000000), 1'b0, m);
    add_row(mk_ray(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 5, 32'h80000000), 1'b0, m);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);
    rows.delete();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        3: begin idle_pct = 29; stall_pct = 29; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int s = 0; s < 2; s++) begin
        set_disk($signed($urandom) >>> $urandom_range(12, 2),
                 $signed($urandom) >>> $urandom_range(12, 2),
                 $signed($urandom) >>> $urandom_range(12, 2),
                 random_normal(), random_normal(), random_normal(),
                 (ph == 4 && s == 1) ? 32'h7fffffff : ($urandom >> $urandom_range(14, 8)));
        if (ph == 4 && s == 0) hold_go = 1'b1;
        // more rays than the pipeline holds while the output is held off
        repeat ((ph == 4 && s == 0) ? 60 : 40) send_ray(random_ray(), 1'b0, m);
        drain();
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (50) @(posedge clk_i);
    $display("Sent %0d rays over %0d register writes; %0d hits and %0d misses checked",
             n_rays, n_cfg, n_hits, n_miss);
    $display("Idle and stall mixes plus one long output hold-off exercised");
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
